// ===== rtl/lhr_pkg.sv =====
// Package for the low-pass hysteresis rounder: widths, reset values,
// register indexes and input mode codes. No dependencies.
`default_nettype none

package lhr_pkg;

  // Default payload geometry
  localparam int unsigned FRAC_BITS_DEF   = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Configuration register widths and reset values
  localparam int unsigned ALPHA_W      = 3;
  localparam int unsigned DEADBAND_W   = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;

  localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 3'd2;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 8'd76;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_SHIFT = 2'd0,
    CFG_DEADBAND    = 2'd1
  } cfg_reg_e;

  // Input item modes
  typedef enum logic {
    MODE_UPDATE = 1'b0,
    MODE_SEED   = 1'b1
  } mode_e;

endpackage : lhr_pkg

`default_nettype wire

// ===== rtl/lhr_stream_if.sv =====
// Valid/ready channel interfaces for the input and result transactions.
// Depends on lhr_pkg for the default sample width.
`default_nettype none

interface lhr_in_if #(
  parameter int unsigned SAMPLE_BITS = lhr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface : lhr_in_if

interface lhr_out_if #(
  parameter int unsigned SAMPLE_BITS = lhr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] display_value;

  modport source (output valid, output display_value, input ready);
  modport sink   (input valid, input display_value, output ready);
endinterface : lhr_out_if

`default_nettype wire

// ===== rtl/lowpass_hysteresis_rounder.sv =====
// Top level: exponential moving average with a hysteresis rounder for display.
// Depends on lhr_pkg and the channel interfaces in lhr_stream_if.sv.
//
//   channel   direction  handshake      payload
//   in_i      sink       valid/ready    mode, sample
//   out_o     source     valid/ready    display_value
//   cfg       write      cfg_we_i       cfg_idx_i, cfg_data_i
//
// One transaction per cycle sustained while out_o is not stalled; an item passes the
// input register, then filter update and rounding into the result register.
// The filter/shown state feeds back within the second stage, so each item
// sees the state left by the one before it.
// Reset clears state to zero, unprimed, with register reset values.
// A stall on out_o holds the result; in_i keeps accepting until both the
// input and the result register are full.
`default_nettype none

module lowpass_hysteresis_rounder #(
  parameter int unsigned FRAC_BITS   = lhr_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = lhr_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  lhr_in_if.sink                               in_i,
  lhr_out_if.source                            out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lhr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lhr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned FW = SAMPLE_BITS + FRAC_BITS;  // filter width
  localparam int unsigned CW = FW + 10;                  // compare width

  localparam logic signed [CW-1:0] HalfC = CW'(1) << (FRAC_BITS - 1);
  localparam logic signed [FW:0]   HalfR = (FW + 1)'(1) << (FRAC_BITS - 1);

  // Configuration registers
  logic [lhr_pkg::ALPHA_W-1:0]    alpha_q;
  logic [lhr_pkg::DEADBAND_W-1:0] deadband_q;

  // Input register
  logic                          s1_valid_q;
  logic                          s1_mode_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;

  // Filter state
  logic signed [FW-1:0]          filt_q, filt_d;
  logic signed [SAMPLE_BITS-1:0] shown_q, shown_d;
  logic                          primed_q;

  // Result register
  logic                          res_valid_q;
  logic signed [SAMPLE_BITS-1:0] res_value_q;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  logic signed [FW-1:0] target;
  logic signed [FW:0]   diff;
  logic signed [FW:0]   step;
  logic signed [FW:0]   sum;
  logic signed [FW-1:0] filt_new;
  logic signed [FW-1:0] shown_scaled;
  logic signed [CW-1:0] filt_x;
  logic signed [CW-1:0] shown_x;
  logic signed [CW-1:0] edge_x;
  logic signed [FW:0]   round_sum;
  logic                 move;

  // Handshake: the result slot frees when empty or being taken
  assign out_free    = !res_valid_q || out_o.ready;
  assign s1_fire     = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign in_fire     = in_i.valid && in_i.ready;

  assign out_o.valid         = res_valid_q;
  assign out_o.display_value = res_value_q;

  // Write configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= lhr_pkg::ALPHA_RESET;
      deadband_q <= lhr_pkg::DEADBAND_RESET;
    end else if (cfg_we_i) begin
      case (lhr_pkg::cfg_reg_e'(cfg_idx_i))
        lhr_pkg::CFG_ALPHA_SHIFT: alpha_q    <= cfg_data_i[lhr_pkg::ALPHA_W-1:0];
        lhr_pkg::CFG_DEADBAND:    deadband_q <= cfg_data_i[lhr_pkg::DEADBAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q   <= in_i.mode;
      s1_sample_q <= in_i.sample;
    end
  end

  // Filter step and hysteresis decision
  always_comb begin
    target    = {s1_sample_q, {FRAC_BITS{1'b0}}};
    diff      = {target[FW-1], target} - {filt_q[FW-1], filt_q};
    step      = diff >>> alpha_q;
    sum       = {filt_q[FW-1], filt_q} + step;
    filt_new  = sum[FW-1:0];

    shown_scaled = {shown_q, {FRAC_BITS{1'b0}}};
    filt_x    = CW'(filt_new);
    shown_x   = CW'(shown_scaled);
    edge_x    = HalfC + CW'($unsigned(deadband_q));
    move      = (filt_x >= shown_x + edge_x) || (filt_x <= shown_x - edge_x);

    round_sum = {filt_new[FW-1], filt_new} + HalfR;

    if (!primed_q || s1_mode_q == lhr_pkg::MODE_SEED) begin
      filt_d  = target;
      shown_d = s1_sample_q;
    end else begin
      filt_d  = filt_new;
      shown_d = move ? round_sum[FW-1:FRAC_BITS] : shown_q;
    end
  end

  // Advance state on each processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q   <= '0;
      shown_q  <= '0;
      primed_q <= 1'b0;
    end else if (s1_fire) begin
      filt_q   <= filt_d;
      shown_q  <= shown_d;
      primed_q <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_value_q <= shown_d;
    end
  end

endmodule : lowpass_hysteresis_rounder

`default_nettype wire

// ===== rtl/lhr_checker.sv =====
// Port-level checker for lowpass_hysteresis_rounder, with its bind statement.
// Depends on lhr_pkg for the default sample width.
`default_nettype none

module lhr_checker #(
  parameter int unsigned SAMPLE_BITS = lhr_pkg::SAMPLE_BITS_DEF
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [SAMPLE_BITS-1:0] display_value_i
);

  logic [1:0] inflight_q;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Track transactions accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 2'(in_fire) - 2'(out_fire);
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(display_value_i))
    else $error("stalled result changed or dropped");

  // No more than two transactions in flight
  a_inflight_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q != 2'd3)
    else $error("more than two transactions in flight");

  // Never show a result without an accepted transaction behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != 2'd0)
    else $error("result without a pending transaction");

  // Input back-pressure only under result back-pressure
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output free");

endmodule : lhr_checker

bind lowpass_hysteresis_rounder lhr_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lhr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .display_value_i(out_o.display_value)
);

`default_nettype wire

// ===== sim/tb_lowpass_hysteresis_rounder.sv =====
// Testbench for lowpass_hysteresis_rounder: directed and random sample streams,
// checked against an in-bench model of the filter and hysteresis rounder.
// Depends on lhr_pkg and the channel interfaces in rtl/lhr_stream_if.sv.
`default_nettype none

module tb_lowpass_hysteresis_rounder;
  import lhr_pkg::*;

  localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
  localparam int FRAC_W         = FRAC_BITS_DEF;
  localparam int ONE_FP         = 1 << FRAC_W;
  localparam int HALF_FP        = ONE_FP / 2;
  localparam int SAMPLE_HI      = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_LO      = -(2 ** (SAMPLE_W - 1));
  localparam int SPARE_W        = CFG_DATA_W - ALPHA_W;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(SAMPLE_HI);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_W'(SAMPLE_LO);

  // Register indexes past the end of the map; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lhr_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_bus ();
  lhr_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_bus ();

  lowpass_hysteresis_rounder #(
    .FRAC_BITS  (FRAC_W),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_bus),
    .out_o     (out_bus),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Filter and display state as the block should hold it
  int                          ema_filter_fp;
  logic signed [SAMPLE_W-1:0]  ema_shown;
  bit                          ema_primed;
  logic [ALPHA_W-1:0]          cfg_alpha;
  logic [DEADBAND_W-1:0]       cfg_deadband;

  logic signed [SAMPLE_W-1:0]  expected_display_q[$];
  int                          err_count;
  int                          burst_left;
  int                          quiet_cycles;
  bit                          tx_steady;
  bit                          rx_steady;

  // Step the filter with one sample and return the integer to be shown
  function automatic logic signed [SAMPLE_W-1:0] next_display(
    input mode_e                      m,
    input logic signed [SAMPLE_W-1:0] s
  );
    int target_fp;
    int shown_scaled;
    int margin;
    if (!ema_primed || m == MODE_SEED) begin
      ema_filter_fp = int'(s) * ONE_FP;
      ema_shown     = s;
      ema_primed    = 1'b1;
    end else begin
      target_fp     = int'(s) * ONE_FP;
      ema_filter_fp = ema_filter_fp + ((target_fp - ema_filter_fp) >>> cfg_alpha);
      shown_scaled  = int'(ema_shown) * ONE_FP;
      margin        = HALF_FP + int'(cfg_deadband);
      if (ema_filter_fp >= shown_scaled + margin ||
          ema_filter_fp <= shown_scaled - margin) begin
        ema_shown = SAMPLE_W'((ema_filter_fp + HALF_FP) >>> FRAC_W);
      end
    end
    return ema_shown;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v > SAMPLE_HI) begin
      return SAMPLE_MAX;
    end else if (v < SAMPLE_LO) begin
      return SAMPLE_MIN;
    end
    return SAMPLE_W'(v);
  endfunction

  function automatic int random_sample();
    return int'($urandom_range(0, 2 ** SAMPLE_W - 1)) + SAMPLE_LO;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Present one transaction, holding it until the block takes it
  task automatic send_item(input mode_e m, input logic signed [SAMPLE_W-1:0] s);
    int gap;
    if (!tx_steady && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk_i);
    in_bus.valid  <= 1'b1;
    in_bus.mode   <= m;
    in_bus.sample <= s;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    expected_display_q.push_back(next_display(m, s));
    if (burst_left > 0) burst_left--;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_display_q.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then give the pipeline time to empty before touching registers
  task automatic settle_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_ALPHA_SHIFT: cfg_alpha    = data[ALPHA_W-1:0];
      CFG_DEADBAND:    cfg_deadband = data[DEADBAND_W-1:0];
      default: ;
    endcase
  endtask

  // First item after reset seeds even in update mode
  task automatic test_unprimed_seed();
    send_item(MODE_UPDATE, SAMPLE_MIN);
    send_item(MODE_UPDATE, SAMPLE_MAX);
    send_item(MODE_UPDATE, SAMPLE_MAX);
  endtask

  // Seed mode reloads filter and display from the top extreme and from zero
  task automatic test_seed_mode();
    send_item(MODE_SEED, SAMPLE_MAX);
    send_item(MODE_UPDATE, SAMPLE_MIN);
    send_item(MODE_SEED, SAMPLE_W'(0));
  endtask

  // Creep up and down with reset values of shift and deadband
  task automatic test_default_hysteresis();
    repeat (3) send_item(MODE_UPDATE, SAMPLE_W'(2));
    repeat (3) send_item(MODE_UPDATE, SAMPLE_W'(-2));
  endtask

  // Land exactly on the half-unit edge with no deadband, both directions
  task automatic test_half_unit_edges();
    settle_idle();
    cfg_write(CFG_ALPHA_SHIFT, CFG_DATA_W'(1));
    cfg_write(CFG_DEADBAND, CFG_DATA_W'(0));
    send_item(MODE_SEED, SAMPLE_W'(0));
    send_item(MODE_UPDATE, SAMPLE_W'(1));
    send_item(MODE_SEED, SAMPLE_W'(0));
    send_item(MODE_UPDATE, SAMPLE_W'(-1));
  endtask

  // Shift of zero: the filter lands on the sample at once
  task automatic test_zero_shift();
    settle_idle();
    cfg_write(CFG_ALPHA_SHIFT, CFG_DATA_W'(0));
    send_item(MODE_UPDATE, SAMPLE_W'(5));
    send_item(MODE_UPDATE, SAMPLE_W'(-5));
    send_item(MODE_UPDATE, SAMPLE_MIN);
  endtask

  // Spare indexes are dropped and data bits above a register are ignored
  task automatic test_register_writes();
    settle_idle();
    cfg_write(CFG_SPARE_A, 8'hFF);
    cfg_write(CFG_ALPHA_SHIFT, 8'hFB);
    cfg_write(CFG_DEADBAND, 8'hFF);
    cfg_write(CFG_SPARE_B, 8'h00);
    send_item(MODE_SEED, SAMPLE_W'(100));
    send_item(MODE_UPDATE, SAMPLE_W'(101));
    send_item(MODE_UPDATE, SAMPLE_W'(101));
    send_item(MODE_UPDATE, SAMPLE_W'(99));
  endtask

  // Noisy, slowly wandering signal with occasional jumps, seeds and extremes
  task automatic test_random_phase(
    input int                    n_items,
    input logic [ALPHA_W-1:0]    alpha,
    input logic [DEADBAND_W-1:0] dband,
    input bit                    steady,
    input bit                    hold_midway
  );
    int    level;
    int    noise;
    int    pick;
    int    val;
    mode_e m;
    settle_idle();
    cfg_write(CFG_ALPHA_SHIFT, {SPARE_W'($urandom()), alpha});
    cfg_write(CFG_DEADBAND, dband);
    tx_steady = steady;
    rx_steady = steady;
    level     = random_sample();
    noise     = $urandom_range(0, 6);
    for (int i = 0; i < n_items; i++) begin
      if (hold_midway && i == n_items / 2) hold_until_drained();
      pick = $urandom_range(0, 99);
      m    = MODE_UPDATE;
      if (pick < 4) begin
        m     = MODE_SEED;
        val   = random_sample();
        level = val;
      end else if (pick < 12) begin
        val = random_sample();
      end else if (pick < 16) begin
        val = (pick % 2 == 0) ? SAMPLE_HI : SAMPLE_LO;
      end else begin
        if (pick < 19) begin
          level = random_sample();
        end else if (pick < 30) begin
          level = level + int'($urandom_range(0, 8)) - 4;
        end
        level = int'(clamp_sample(level));
        val   = level + int'($urandom_range(0, 2 * noise)) - noise;
      end
      send_item(m, clamp_sample(val));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: alternate ready runs and stalls unless told to stay ready
  initial begin
    int run_left;
    bit ready_hi;
    out_bus.ready = 1'b0;
    run_left      = 0;
    ready_hi      = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_steady) begin
        out_bus.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_hi = !ready_hi;
          run_left = ready_hi ? $urandom_range(1, 10) : $urandom_range(1, 5);
        end
        run_left--;
        out_bus.ready <= ready_hi;
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_display_q.size() == 0) begin
        $error("display_value with no expectation waiting: got %0d", out_bus.display_value);
        err_count++;
      end else begin
        want = expected_display_q.pop_front();
        if (out_bus.display_value !== want) begin
          $error("display_value mismatch: expected %0d, got %0d", want,
                 out_bus.display_value);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_lowpass_hysteresis_rounder: done, errors");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni        = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.mode   = MODE_UPDATE;
    in_bus.sample = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_ALPHA_SHIFT;
    cfg_data_i    = '0;
    ema_filter_fp = 0;
    ema_shown     = '0;
    ema_primed    = 1'b0;
    cfg_alpha     = ALPHA_RESET;
    cfg_deadband  = DEADBAND_RESET;
    err_count     = 0;
    burst_left    = 0;
    quiet_cycles  = 0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_unprimed_seed();
    test_seed_mode();
    test_default_hysteresis();
    test_half_unit_edges();
    test_zero_shift();
    test_register_writes();

    test_random_phase(142, 3'd0, 8'd0, 1'b0, 1'b0);
    test_random_phase(142, 3'd7, 8'd255, 1'b0, 1'b0);
    test_random_phase(142, 3'd0, 8'd255, 1'b0, 1'b1);
    test_random_phase(142, 3'd7, 8'd0, 1'b1, 1'b0);
    test_random_phase(142, ALPHA_W'($urandom()), DEADBAND_W'($urandom()), 1'b0, 1'b0);
    test_random_phase(142, ALPHA_W'($urandom()), DEADBAND_W'($urandom()), 1'b0, 1'b1);
    test_random_phase(142, ALPHA_RESET, DEADBAND_RESET, 1'b0, 1'b0);
    test_random_phase(142, ALPHA_W'($urandom()), DEADBAND_W'($urandom()), 1'b1, 1'b0);

    // Let the last results out, then allow for any stray transaction
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_display_q.size() != 0) begin
      $error("display_value: %0d expected results never arrived",
             expected_display_q.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("tb_lowpass_hysteresis_rounder: done, clean");
    end else begin
      $display("tb_lowpass_hysteresis_rounder: done, errors");
    end
    $finish;
  end

endmodule : tb_lowpass_hysteresis_rounder

`default_nettype wire

// ===== lowpass_hysteresis_rounder.f =====
rtl/lhr_pkg.sv
rtl/lhr_stream_if.sv
rtl/lowpass_hysteresis_rounder.sv
rtl/lhr_checker.sv
sim/tb_lowpass_hysteresis_rounder.sv
